// File: hdl/json_structure_writer_core_macros.svh
// assertion helpers shared by the writer modules
`ifndef JSON_STRUCTURE_WRITER_CORE_MACROS_SVH
`define JSON_STRUCTURE_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define JSW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define JSW_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define JSW_ASSERT(label, clk, rst, prop, msg)

`define JSW_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// File: hdl/jsw_pkg.sv
`timescale 1ns / 1ps

package jsw_pkg;

   // default build parameters
   localparam int DEF_MAX_DEPTH   = 8;
   localparam int DEF_INDENT_STEP = 4;

   // fixed field widths
   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;

   // structural commands
   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN_OBJ  = 3'd0,
      CMD_CLOSE_OBJ = 3'd1,
      CMD_OPEN_ARR  = 3'd2,
      CMD_CLOSE_ARR = 3'd3,
      CMD_KEY_BEGIN = 3'd4,
      CMD_KEY_END   = 3'd5,
      CMD_VALUE     = 3'd6,
      CMD_TEXT      = 3'd7
   } cmd_type;

   // per item status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_KEY_OUTSIDE = 3'd1,
      ST_IMBALANCE   = 3'd2,
      ST_MISMATCH    = 3'd3,
      ST_SECOND_ROOT = 3'd4,
      ST_DEPTH_OVF   = 3'd5
   } status_type;

   // characters
   localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSLASH   = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_SLASH    = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
   localparam logic [BYTE_W-1:0] CH_FF       = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LOW_B    = 8'h62;
   localparam logic [BYTE_W-1:0] CH_LOW_F    = 8'h66;
   localparam logic [BYTE_W-1:0] CH_LOW_N    = 8'h6E;
   localparam logic [BYTE_W-1:0] CH_LOW_R    = 8'h72;
   localparam logic [BYTE_W-1:0] CH_LOW_T    = 8'h74;
   localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_COLON    = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_LBRACE   = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;

   // which character the datapath puts into the result register
   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_COMMA,
      SEL_NL,
      SEL_SPACE,
      SEL_TAIL
   } sel_type;

   // shape of the character run of one item
   typedef struct packed {
      logic       comma;
      logic       newline;
      logic       indent_nz;
      logic [1:0] ntail;
   } plan_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    emit;
      sel_type sel;
      logic    last;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      plan_type plan;
      plan_type plan_next;
      logic     indent_last;
      logic     tail_last;
      logic     out_free;
   } dp_sts_type;

   // escape letter for a byte, zero when the byte needs no escape
   function automatic logic [BYTE_W-1:0] escape_code(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      case (b)
         CH_QUOTE:  r = CH_QUOTE;
         CH_BSLASH: r = CH_BSLASH;
         CH_SLASH:  r = CH_SLASH;
         CH_BS:     r = CH_LOW_B;
         CH_FF:     r = CH_LOW_F;
         CH_LF:     r = CH_LOW_N;
         CH_CR:     r = CH_LOW_R;
         CH_TAB:    r = CH_LOW_T;
         default:   r = CH_NUL;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/jsw_req_if.sv
`timescale 1ns / 1ps

// command item channel
interface jsw_req_if import jsw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] text_byte;
   logic              escape_on;

   modport source (output valid, cmd, text_byte, escape_on, input ready);
   modport sink   (input valid, cmd, text_byte, escape_on, output ready);
endinterface

// File: hdl/jsw_rsp_if.sv
`timescale 1ns / 1ps

// character item channel
interface jsw_rsp_if import jsw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                byte_valid;
   logic                last_of_run;
   logic [STATUS_W-1:0] status;
   logic                doc_complete;

   modport source (output valid, out_byte, byte_valid, last_of_run, status, doc_complete,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, last_of_run, status, doc_complete,
                   output ready);
endinterface

// File: hdl/json_structure_writer_core.sv
// an item is taken into the run registers, and its first character item is written into
// the result register once that register is free; the next item is taken only after
// the last character item of the run has been written
// reset: synchronous; clears nesting depth, root and error flags, pretty mode, the run
// sequencer state and the result valid flag; the nesting stack itself is not cleared
`timescale 1ns / 1ps

module json_structure_writer_core import jsw_pkg::*; #(
   parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
   parameter int INDENT_STEP = DEF_INDENT_STEP
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_wdata,
   jsw_req_if.sink      req_ch,
   jsw_rsp_if.source    rsp_ch
);

   ctrl_cmd_type ctl_cmd;
   dp_sts_type   dp_sts;

   // run sequencer
   jsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (dp_sts),
      .ctl_cmd   (ctl_cmd)
   );

   // document state, decode and result register
   jsw_datapath #(
      .MAX_DEPTH   (MAX_DEPTH),
      .INDENT_STEP (INDENT_STEP)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .item_cmd       (req_ch.cmd),
      .item_text      (req_ch.text_byte),
      .item_escape    (req_ch.escape_on),
      .ctl_cmd        (ctl_cmd),
      .sts            (dp_sts),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_byte       (rsp_ch.out_byte),
      .rsp_byte_valid (rsp_ch.byte_valid),
      .rsp_last       (rsp_ch.last_of_run),
      .rsp_status     (rsp_ch.status),
      .rsp_doc        (rsp_ch.doc_complete)
   );

endmodule

// File: hdl/jsw_ctrl.sv
`timescale 1ns / 1ps
`include "json_structure_writer_core_macros.svh"

module jsw_ctrl import jsw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_sts_type   sts,
   output ctrl_cmd_type ctl_cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMMA,
      S_NL,
      S_INDENT,
      S_TAIL,
      S_NONE
   } state_type;

   state_type state_ff, state_in;

   // next phase of the run that is present, from a given phase
   function automatic state_type after_phase(input state_type ph, input plan_type p);
      state_type r;
      unique case (ph)
         S_IDLE: begin
            if (p.comma)
               r = S_COMMA;
            else if (p.newline)
               r = S_NL;
            else if (p.indent_nz)
               r = S_INDENT;
            else if (p.ntail != 2'd0)
               r = S_TAIL;
            else
               r = S_NONE;
         end
         S_COMMA: begin
            if (p.newline)
               r = S_NL;
            else if (p.indent_nz)
               r = S_INDENT;
            else if (p.ntail != 2'd0)
               r = S_TAIL;
            else
               r = S_IDLE;
         end
         S_NL: begin
            if (p.indent_nz)
               r = S_INDENT;
            else if (p.ntail != 2'd0)
               r = S_TAIL;
            else
               r = S_IDLE;
         end
         S_INDENT: begin
            r = (p.ntail != 2'd0) ? S_TAIL : S_IDLE;
         end
         default: begin
            r = S_IDLE;
         end
      endcase
      return r;
   endfunction

   // take an item only between runs
   assign req_ready = (state_ff == S_IDLE) && !reset;

   // sequencing of the character run
   always_comb begin
      state_in        = state_ff;
      ctl_cmd         = '0;
      ctl_cmd.sel     = SEL_NONE;
      ctl_cmd.load    = req_valid && req_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl_cmd.load)
               state_in = after_phase(S_IDLE, sts.plan_next);
         end
         S_COMMA, S_NL, S_INDENT, S_TAIL, S_NONE: begin
            if (sts.out_free) begin
               ctl_cmd.emit = 1'b1;
               if ((state_ff == S_INDENT && !sts.indent_last) ||
                   (state_ff == S_TAIL && !sts.tail_last))
                  state_in = state_ff;
               else
                  state_in = after_phase(state_ff, sts.plan);
               ctl_cmd.last = (state_in == S_IDLE);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      unique case (state_ff)
         S_COMMA:  ctl_cmd.sel = SEL_COMMA;
         S_NL:     ctl_cmd.sel = SEL_NL;
         S_INDENT: ctl_cmd.sel = SEL_SPACE;
         S_TAIL:   ctl_cmd.sel = SEL_TAIL;
         default:  ctl_cmd.sel = SEL_NONE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `JSW_ASSERT(a_emit_needs_slot, clock, reset, ctl_cmd.emit |-> sts.out_free, "emit into a full slot")
   `JSW_ASSERT(a_item_gives_result, clock, reset, ctl_cmd.load |=> (state_ff != S_IDLE), "item without result")
   `JSW_ASSERT(a_last_ends_run, clock, reset, (ctl_cmd.emit && ctl_cmd.last) |=> (state_ff == S_IDLE), "run did not end")
   `JSW_ASSERT_NEVER(a_no_load_in_run, clock, reset, ctl_cmd.load && ctl_cmd.emit, "load during a run")

endmodule

// File: hdl/jsw_datapath.sv
`timescale 1ns / 1ps
`include "json_structure_writer_core_macros.svh"

module jsw_datapath import jsw_pkg::*; #(
   parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
   parameter int INDENT_STEP = DEF_INDENT_STEP
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_wdata,
   input  logic [CMD_W-1:0]    item_cmd,
   input  logic [BYTE_W-1:0]   item_text,
   input  logic                item_escape,
   input  ctrl_cmd_type        ctl_cmd,
   output dp_sts_type          sts,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [BYTE_W-1:0]   rsp_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_last,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_doc
);

   localparam int DEP_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int IND_W = $clog2(MAX_DEPTH * INDENT_STEP + 1);

   // document state
   logic             pretty_ff;
   logic [DEP_W-1:0] depth_ff, depth_in;
   logic             root_ff, root_in;
   logic             err_ff, err_in;
   logic             is_arr_ff  [MAX_DEPTH];
   logic             has_val_ff [MAX_DEPTH];

   // run of the current item
   plan_type          plan_ff, plan_in;
   status_type        step_status_ff, status_in;
   logic              step_doc_ff, doc_in;
   logic [BYTE_W-1:0] tail_ff [3];
   logic [BYTE_W-1:0] tail_in [3];
   logic [IND_W-1:0]  ind_cnt_ff, ind_in;
   logic [1:0]        tail_idx_ff;

   // result register
   logic                out_valid_ff;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic                out_bvalid_ff;
   logic                out_last_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic                out_doc_ff;

   cmd_type           cmd_dec;
   logic              depth_empty;
   logic [DEP_W-1:0]  depth_dec;
   logic [IDX_W-1:0]  top_idx, push_idx;
   logic              top_arr, top_hv;
   logic [IND_W-1:0]  ind_cur, ind_pop;
   logic [BYTE_W-1:0] esc_char;
   logic              push_en, push_arr, mark_en;
   logic              out_free;
   logic [BYTE_W-1:0] sel_byte;
   logic              sel_bvalid;

   assign cmd_dec     = cmd_type'(item_cmd);
   assign depth_empty = (depth_ff == '0);
   assign depth_dec   = depth_ff - DEP_W'(1);
   assign top_idx     = depth_dec[IDX_W-1:0];
   assign push_idx    = depth_ff[IDX_W-1:0];
   assign top_arr     = is_arr_ff[top_idx];
   assign top_hv      = has_val_ff[top_idx];
   assign ind_cur     = IND_W'(depth_ff * INDENT_STEP);
   assign ind_pop     = IND_W'(depth_dec * INDENT_STEP);
   assign esc_char    = escape_code(item_text);

   // decode an item into its run and the state it leaves
   always_comb begin
      plan_in    = '0;
      status_in  = ST_OK;
      depth_in   = depth_ff;
      root_in    = root_ff;
      ind_in     = '0;
      push_en    = 1'b0;
      push_arr   = 1'b0;
      mark_en    = 1'b0;
      tail_in[0] = CH_NUL;
      tail_in[1] = CH_NUL;
      tail_in[2] = CH_NUL;
      unique case (cmd_dec) inside
         CMD_OPEN_OBJ, CMD_OPEN_ARR: begin
            if (depth_empty && root_ff) begin
               status_in = ST_SECOND_ROOT;
            end else if (depth_ff >= DEP_W'(MAX_DEPTH)) begin
               status_in = ST_DEPTH_OVF;
            end else begin
               if (depth_empty) begin
                  root_in = 1'b1;
               end else begin
                  mark_en = 1'b1;
                  if (top_arr) begin
                     plan_in.comma   = top_hv;
                     plan_in.newline = pretty_ff;
                     ind_in          = pretty_ff ? ind_cur : '0;
                  end
               end
               push_en       = 1'b1;
               push_arr      = (cmd_dec == CMD_OPEN_ARR);
               depth_in      = depth_ff + DEP_W'(1);
               tail_in[0]    = push_arr ? CH_LBRACKET : CH_LBRACE;
               plan_in.ntail = 2'd1;
            end
         end
         CMD_CLOSE_OBJ, CMD_CLOSE_ARR: begin
            if (depth_empty) begin
               status_in = ST_IMBALANCE;
            end else begin
               depth_in = depth_dec;
               if (top_arr != (cmd_dec == CMD_CLOSE_ARR)) begin
                  status_in = ST_MISMATCH;
               end else begin
                  if (pretty_ff && top_hv) begin
                     plan_in.newline = 1'b1;
                     ind_in          = ind_pop;
                  end
                  tail_in[0]    = top_arr ? CH_RBRACKET : CH_RBRACE;
                  plan_in.ntail = 2'd1;
               end
            end
         end
         CMD_KEY_BEGIN: begin
            if (depth_empty || top_arr) begin
               status_in = ST_KEY_OUTSIDE;
            end else begin
               plan_in.comma   = top_hv;
               plan_in.newline = pretty_ff;
               ind_in          = pretty_ff ? ind_cur : '0;
               tail_in[0]      = CH_QUOTE;
               plan_in.ntail   = 2'd1;
            end
         end
         CMD_KEY_END: begin
            if (depth_empty || top_arr) begin
               status_in = ST_KEY_OUTSIDE;
            end else begin
               tail_in[0]    = CH_QUOTE;
               tail_in[1]    = CH_COLON;
               tail_in[2]    = CH_SPACE;
               plan_in.ntail = pretty_ff ? 2'd3 : 2'd2;
            end
         end
         CMD_VALUE: begin
            if (depth_empty) begin
               if (root_ff)
                  status_in = ST_SECOND_ROOT;
               else
                  root_in = 1'b1;
            end else begin
               mark_en = 1'b1;
               if (top_arr) begin
                  plan_in.comma   = top_hv;
                  plan_in.newline = pretty_ff;
                  ind_in          = pretty_ff ? ind_cur : '0;
               end
            end
         end
         default: begin
            if (item_escape && esc_char != CH_NUL) begin
               tail_in[0]    = CH_BSLASH;
               tail_in[1]    = esc_char;
               plan_in.ntail = 2'd2;
            end else begin
               tail_in[0]    = item_text;
               plan_in.ntail = 2'd1;
            end
         end
      endcase
      plan_in.indent_nz = (ind_in != '0);
      err_in = err_ff || (status_in != ST_OK);
      doc_in = !err_in && (depth_in == '0) && root_in;
   end

   // document state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pretty_ff <= 1'b0;
         depth_ff  <= '0;
         root_ff   <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         if (csr_we)
            pretty_ff <= csr_wdata;
         if (ctl_cmd.load) begin
            depth_ff <= depth_in;
            root_ff  <= root_in;
            err_ff   <= err_in;
         end
      end
   end

   // nesting stack, no reset: entries are read only after an open wrote them
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         if (mark_en)
            has_val_ff[top_idx] <= 1'b1;
         if (push_en) begin
            is_arr_ff[push_idx]  <= push_arr;
            has_val_ff[push_idx] <= 1'b0;
         end
      end
   end

   // run description and counters
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         plan_ff        <= plan_in;
         step_status_ff <= status_in;
         step_doc_ff    <= doc_in;
         tail_ff        <= tail_in;
         ind_cnt_ff     <= ind_in;
         tail_idx_ff    <= 2'd0;
      end else if (ctl_cmd.emit) begin
         if (ctl_cmd.sel == SEL_SPACE)
            ind_cnt_ff <= ind_cnt_ff - IND_W'(1);
         if (ctl_cmd.sel == SEL_TAIL)
            tail_idx_ff <= tail_idx_ff + 2'd1;
      end
   end

   // character for the current phase
   always_comb begin
      sel_bvalid = 1'b1;
      case (ctl_cmd.sel)
         SEL_COMMA: sel_byte = CH_COMMA;
         SEL_NL:    sel_byte = CH_LF;
         SEL_SPACE: sel_byte = CH_SPACE;
         SEL_TAIL:  sel_byte = tail_ff[tail_idx_ff];
         default: begin
            sel_byte   = CH_NUL;
            sel_bvalid = 1'b0;
         end
      endcase
   end

   assign out_free = !out_valid_ff || rsp_ready;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl_cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.emit) begin
         out_byte_ff   <= sel_byte;
         out_bvalid_ff <= sel_bvalid;
         out_last_ff   <= ctl_cmd.last;
         out_status_ff <= step_status_ff;
         out_doc_ff    <= step_doc_ff;
      end
   end

   // status toward the controller
   always_comb begin
      sts             = '0;
      sts.plan        = plan_ff;
      sts.plan_next   = plan_in;
      sts.indent_last = (ind_cnt_ff == IND_W'(1));
      sts.tail_last   = (tail_idx_ff == (plan_ff.ntail - 2'd1));
      sts.out_free    = out_free;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_byte       = out_byte_ff;
   assign rsp_byte_valid = out_bvalid_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_doc        = out_doc_ff;

   `JSW_ASSERT(a_depth_bound, clock, reset, depth_ff <= DEP_W'(MAX_DEPTH), "depth past limit")
   `JSW_ASSERT(a_error_sticky, clock, reset, err_ff |=> err_ff, "error flag cleared")
   `JSW_ASSERT(a_done_is_ok, clock, reset, (out_valid_ff && out_doc_ff) |-> (out_status_ff == ST_OK), "complete with error")
   `JSW_ASSERT_NEVER(a_no_emit_on_full, clock, reset, ctl_cmd.emit && !out_free, "result overwritten")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import jsw_pkg::*;

   localparam int DEPTH_LIMIT = DEF_MAX_DEPTH;
   localparam int INDENT      = DEF_INDENT_STEP;
   localparam int MAX_RUN     = 63;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_LIMIT  = 10;

   typedef struct {
      cmd_type     cmd;
      logic [7:0]  text_byte;
      logic        escape_on;
   } cmd_item_type;

   typedef struct {
      logic [7:0]  ch;
      logic        bv;
      logic        last;
      status_type  status;
      logic        done;
   } char_item_type;

   bit   clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;
   logic hold_off = 1'b0;
   logic req_taken = 1'b0;
   int   phase = 0;
   int   cycle_count = 0;
   int   fail_count = 0;

   jsw_req_if req_bus ();
   jsw_rsp_if rsp_bus ();

   json_structure_writer_core #(
      .MAX_DEPTH   (DEPTH_LIMIT),
      .INDENT_STEP (INDENT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   // writer state as the block should hold it
   logic          lvl_is_arr [DEPTH_LIMIT];
   logic          lvl_has_vals [DEPTH_LIMIT];
   int            lvl_count = 0;
   logic          root_seen = 1'b0;
   logic          err_sticky = 1'b0;
   logic          pretty_on = 1'b0;
   logic [7:0]    run_chars[$];
   char_item_type expected_chars[$];

   // pending command items and the shape of the structure they build
   cmd_item_type  item_q[$];
   bit            gen_arr[$];
   bit            gen_root = 1'b0;
   int            gen_count = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void put_char(input logic [7:0] c);
      if (run_chars.size() < MAX_RUN) run_chars.insert(run_chars.size(), c);
   endfunction

   function automatic void put_line_break();
      put_char(CH_LF);
      repeat (lvl_count * INDENT) put_char(CH_SPACE);
   endfunction

   function automatic logic [7:0] escape_letter(input logic [7:0] b);
      case (b)
         CH_QUOTE:  return CH_QUOTE;
         CH_BSLASH: return CH_BSLASH;
         CH_SLASH:  return CH_SLASH;
         CH_BS:     return CH_LOW_B;
         CH_FF:     return CH_LOW_F;
         CH_LF:     return CH_LOW_N;
         CH_CR:     return CH_LOW_R;
         CH_TAB:    return CH_LOW_T;
         default:   return CH_NUL;
      endcase
   endfunction

   // a new value in the current level: comma and line break inside arrays
   function automatic status_type admit_entry();
      int t;
      if (lvl_count == 0) begin
         if (root_seen) return ST_SECOND_ROOT;
         root_seen = 1'b1;
         return ST_OK;
      end
      t = lvl_count - 1;
      if (lvl_is_arr[t]) begin
         if (lvl_has_vals[t]) put_char(CH_COMMA);
         if (pretty_on) put_line_break();
      end
      lvl_has_vals[t] = 1'b1;
      return ST_OK;
   endfunction

   function automatic logic in_object();
      if (lvl_count == 0) return 1'b0;
      return !lvl_is_arr[lvl_count - 1];
   endfunction

   function automatic void writer_step(input cmd_item_type it);
      status_type    st;
      logic          want_arr;
      logic          popped;
      logic [7:0]    code;
      logic          done;
      char_item_type r;
      int            t;
      st = ST_OK;
      run_chars.delete();
      want_arr = (it.cmd == CMD_OPEN_ARR || it.cmd == CMD_CLOSE_ARR);
      case (it.cmd)
         CMD_OPEN_OBJ, CMD_OPEN_ARR: begin
            if (lvl_count == 0 && root_seen) begin
               st = ST_SECOND_ROOT;
            end else if (lvl_count >= DEPTH_LIMIT) begin
               st = ST_DEPTH_OVF;
            end else begin
               st = admit_entry();
               lvl_is_arr[lvl_count] = want_arr;
               lvl_has_vals[lvl_count] = 1'b0;
               lvl_count++;
               put_char(want_arr ? CH_LBRACKET : CH_LBRACE);
            end
         end
         CMD_CLOSE_OBJ, CMD_CLOSE_ARR: begin
            if (lvl_count == 0) begin
               st = ST_IMBALANCE;
            end else begin
               t = lvl_count - 1;
               popped = lvl_is_arr[t];
               lvl_count--;
               if (popped != want_arr) begin
                  st = ST_MISMATCH;
               end else begin
                  if (pretty_on && lvl_has_vals[t]) put_line_break();
                  put_char(want_arr ? CH_RBRACKET : CH_RBRACE);
               end
            end
         end
         CMD_KEY_BEGIN: begin
            if (!in_object()) begin
               st = ST_KEY_OUTSIDE;
            end else begin
               if (lvl_has_vals[lvl_count - 1]) put_char(CH_COMMA);
               if (pretty_on) put_line_break();
               put_char(CH_QUOTE);
            end
         end
         CMD_KEY_END: begin
            if (!in_object()) begin
               st = ST_KEY_OUTSIDE;
            end else begin
               put_char(CH_QUOTE);
               put_char(CH_COLON);
               if (pretty_on) put_char(CH_SPACE);
            end
         end
         CMD_VALUE: st = admit_entry();
         default: begin
            code = it.escape_on ? escape_letter(it.text_byte) : CH_NUL;
            if (code != CH_NUL) begin
               put_char(CH_BSLASH);
               put_char(code);
            end else begin
               put_char(it.text_byte);
            end
         end
      endcase

      if (st != ST_OK) err_sticky = 1'b1;
      done = !err_sticky && lvl_count == 0 && root_seen;

      // a step with no characters still gives one empty item
      if (run_chars.size() == 0) begin
         r.ch = CH_NUL; r.bv = 1'b0; r.last = 1'b1; r.status = st; r.done = done;
         expected_chars.insert(expected_chars.size(), r);
      end
      foreach (run_chars[k]) begin
         r.ch = run_chars[k];
         r.bv = 1'b1;
         r.last = (k == run_chars.size() - 1);
         r.status = st;
         r.done = done;
         expected_chars.insert(expected_chars.size(), r);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void queue_cmd(input cmd_type c, input logic [7:0] b, input logic e);
      cmd_item_type it;
      it.cmd = c; it.text_byte = b; it.escape_on = e;
      item_q.insert(item_q.size(), it);
      gen_count++;
      // mirror how the nesting depth moves
      case (c)
         CMD_OPEN_OBJ, CMD_OPEN_ARR: begin
            if ((gen_arr.size() != 0 || !gen_root) && gen_arr.size() < DEPTH_LIMIT) begin
               gen_root = 1'b1;
               gen_arr.insert(gen_arr.size(), c == CMD_OPEN_ARR);
            end
         end
         CMD_CLOSE_OBJ, CMD_CLOSE_ARR: begin
            if (gen_arr.size() != 0) void'(gen_arr.pop_back());
         end
         CMD_VALUE: begin
            if (gen_arr.size() == 0) gen_root = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // text bytes lean toward the characters that have escapes
   function automatic logic [7:0] rand_text();
      if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0: return CH_QUOTE;
         1: return CH_BSLASH;
         2: return CH_SLASH;
         3: return CH_BS;
         4: return CH_FF;
         5: return CH_LF;
         6: return CH_CR;
         default: return CH_TAB;
      endcase
   endfunction

   function automatic void queue_any(input cmd_type c);
      queue_cmd(c, rand_text(), 1'($urandom_range(0, 1)));
   endfunction

   function automatic void queue_scalar();
      queue_any(CMD_VALUE);
      repeat ($urandom_range(1, 4)) queue_any(CMD_TEXT);
   endfunction

   function automatic void queue_key();
      queue_any(CMD_KEY_BEGIN);
      repeat ($urandom_range(1, 3)) queue_any(CMD_TEXT);
      queue_any(CMD_KEY_END);
   endfunction

   // root array left open so that the rest of the run can nest inside it
   function automatic void build_directed();
      queue_cmd(CMD_OPEN_ARR, 8'h00, 1'b0);
      queue_cmd(CMD_VALUE, 8'hFF, 1'b1);
      queue_cmd(CMD_TEXT, 8'h00, 1'b1);
      queue_cmd(CMD_TEXT, 8'hFF, 1'b0);
      queue_cmd(CMD_TEXT, CH_QUOTE, 1'b1);
      queue_cmd(CMD_TEXT, CH_BSLASH, 1'b1);
      queue_cmd(CMD_TEXT, CH_SLASH, 1'b1);
      queue_cmd(CMD_TEXT, CH_BS, 1'b1);
      queue_cmd(CMD_TEXT, CH_FF, 1'b1);
      queue_cmd(CMD_TEXT, CH_LF, 1'b1);
      queue_cmd(CMD_TEXT, CH_CR, 1'b1);
      queue_cmd(CMD_TEXT, CH_TAB, 1'b1);
      queue_cmd(CMD_TEXT, CH_QUOTE, 1'b0);
      // keys inside an array
      queue_cmd(CMD_KEY_BEGIN, 8'h41, 1'b0);
      queue_cmd(CMD_KEY_END, 8'h42, 1'b1);
      // object with one member, then an array that is closed the wrong way
      queue_cmd(CMD_OPEN_OBJ, 8'h00, 1'b0);
      queue_cmd(CMD_KEY_BEGIN, 8'h00, 1'b0);
      queue_cmd(CMD_TEXT, 8'h61, 1'b1);
      queue_cmd(CMD_KEY_END, 8'h00, 1'b0);
      queue_cmd(CMD_VALUE, 8'h00, 1'b0);
      queue_cmd(CMD_TEXT, 8'h31, 1'b0);
      queue_cmd(CMD_OPEN_ARR, 8'h00, 1'b0);
      queue_cmd(CMD_CLOSE_OBJ, 8'h00, 1'b0);
      queue_cmd(CMD_CLOSE_OBJ, 8'h00, 1'b0);
   endfunction

   // mostly well-formed members with random content, some noise
   function automatic void build_random(input int n);
      int      r;
      int      d;
      bit      top;
      cmd_type c;
      gen_count = 0;
      while (gen_count < n) begin
         d = gen_arr.size();
         top = gen_arr[d - 1];
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 15) begin
            c = cmd_type'($urandom_range(0, 7));
            // never close the root here
            if ((c == CMD_CLOSE_OBJ || c == CMD_CLOSE_ARR) && d <= 1) c = CMD_TEXT;
            queue_any(c);
         end else if (d > 1 && r < 15 + 3 * d) begin
            queue_any(top ? CMD_CLOSE_ARR : CMD_CLOSE_OBJ);
         end else begin
            if (!top) queue_key();
            if (r >= 60) queue_any($urandom_range(0, 1) ? CMD_OPEN_ARR : CMD_OPEN_OBJ);
            else queue_scalar();
         end
      end
   endfunction

   // deepest nesting and overflow, unwind, then errors on the empty stack
   function automatic void build_tail();
      while (gen_arr.size() < DEPTH_LIMIT)
         queue_any($urandom_range(0, 1) ? CMD_OPEN_ARR : CMD_OPEN_OBJ);
      queue_any(CMD_VALUE);
      queue_any(CMD_TEXT);
      queue_any(CMD_OPEN_OBJ);
      while (gen_arr.size() != 0)
         queue_any(gen_arr[gen_arr.size() - 1] ? CMD_CLOSE_ARR : CMD_CLOSE_OBJ);
      queue_any(CMD_CLOSE_ARR);
      queue_any(CMD_KEY_BEGIN);
      queue_any(CMD_OPEN_OBJ);
      queue_any(CMD_VALUE);
      queue_any(CMD_TEXT);
   endfunction

   task automatic wait_drained();
      while (item_q.size() != 0 || req_bus.valid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_pretty(input logic v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      pretty_on = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : main_seq
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_pretty(1'b0);
      build_directed();
      wait_drained();

      phase = 1;
      set_pretty(1'b1);
      build_random(100);
      wait_drained();

      phase = 2;
      set_pretty(1'b0);
      build_random(100);
      wait_drained();

      phase = 3;
      set_pretty(1'b1);
      build_random(100);
      build_tail();
      wait_drained();

      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_chars.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // long receiver hold-off early in the first random phase
   initial begin : rsp_hold
      while (phase != 1) @(negedge clock);
      repeat (20) @(negedge clock);
      hold_off <= 1'b1;
      repeat (300) @(negedge clock);
      hold_off <= 1'b0;
   end

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : drive_req
      cmd_item_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.cmd <= CMD_OPEN_OBJ;
         req_bus.text_byte <= 8'h00;
         req_bus.escape_on <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (item_q.size() != 0 && !(phase != 2 && $urandom_range(0, 99) < 14)) begin
            nxt = item_q.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.cmd <= nxt.cmd;
            req_bus.text_byte <= nxt.text_byte;
            req_bus.escape_on <= nxt.escape_on;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_ready
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !hold_off && !(phase != 2 && $urandom_range(0, 99) < 14);
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : watch_items
      cmd_item_type  it;
      char_item_type want;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         // predict first so a same-edge result would still find its expectation
         if (req_bus.valid && req_bus.ready) begin
            it.cmd = cmd_type'(req_bus.cmd);
            it.text_byte = req_bus.text_byte;
            it.escape_on = req_bus.escape_on;
            writer_step(it);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_chars.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT)
                  $display("tb: unexpected item byte %h valid %b last %b status %0d done %b",
                           rsp_bus.out_byte, rsp_bus.byte_valid, rsp_bus.last_of_run,
                           rsp_bus.status, rsp_bus.doc_complete);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_bus.out_byte !== want.ch || rsp_bus.byte_valid !== want.bv ||
                   rsp_bus.last_of_run !== want.last || rsp_bus.status !== want.status ||
                   rsp_bus.doc_complete !== want.done) begin
                  fail_count++;
                  if (fail_count <= SHOW_LIMIT)
                     $display("tb: mismatch at cycle %0d: want %h/%b/%b/%0d/%b got %h/%b/%b/%0d/%b",
                              cycle_count, want.ch, want.bv, want.last, want.status, want.done,
                              rsp_bus.out_byte, rsp_bus.byte_valid, rsp_bus.last_of_run,
                              rsp_bus.status, rsp_bus.doc_complete);
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin : run_limit
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/jsw_pkg.sv
hdl/jsw_req_if.sv
hdl/jsw_rsp_if.sv
hdl/jsw_ctrl.sv
hdl/jsw_datapath.sv
hdl/json_structure_writer_core.sv
tb/tb.sv
